>>> src/tchc_pkg.sv
// shared constants and types of the two-choice hash counter
package tchc_pkg;

	localparam int TABLE_HALF = 16384;
	localparam int MAX_PROBES = 128;

	localparam int SLOTS = 2 * TABLE_HALF;
	localparam int HW    = $clog2(TABLE_HALF);
	localparam int AW    = $clog2(SLOTS);
	localparam int PW    = $clog2(MAX_PROBES + 1);

	localparam int KEY_W = 62;
	localparam int CNT_W = 32;
	localparam int UNQ_W = 16;
	localparam int IDX_W = 15;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int          MIX_SH = 33;

	localparam logic [1:0] ST_INC  = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_DROP = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} row_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
		logic             occ;
	} res_t;

endpackage

>>> src/tchc_if.sv
// request and response channel interfaces
interface tchc_in_if import tchc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [KEY_W-1:0] key_in;
	logic [IDX_W-1:0] slot_index;

	modport source (output valid, opcode, key_in, slot_index, input ready);
	modport sink   (input valid, opcode, key_in, slot_index, output ready);
endinterface

interface tchc_out_if import tchc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] slot_out;
	logic [KEY_W-1:0] key_out;
	logic [CNT_W-1:0] count_out;
	logic             occupied;
	logic [UNQ_W-1:0] unique_total;

	modport source (output valid, status, slot_out, key_out, count_out, occupied,
		unique_total, input ready);
	modport sink   (input valid, status, slot_out, key_out, count_out, occupied,
		unique_total, output ready);
endinterface

>>> src/tchc_ram.sv
// generic single-port ram with registered read
module tchc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] addr,
	input  logic [W-1:0]         wdata,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> src/two_choice_hash_counter.sv
// two-choice hash counter top level: slot table, hash sequencer, result register
// count word: slot reads, 64-bit mix in 32x32 parts, then a linear probe of at most
// MAX_PROBES slots; read word: one slot read
// one word at a time, each finished before the next is taken; a new
// word is taken while the last result still waits in the output register
// after reset a clearing pass over all 2*TABLE_HALF slots (32768) empties the table
module two_choice_hash_counter import tchc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tchc_in_if.sink    req,
	tchc_out_if.source rsp
);
	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_M1    = 10'b0000000100,
		S_A1    = 10'b0000001000,
		S_M2    = 10'b0000010000,
		S_A2    = 10'b0000100000,
		S_CHK   = 10'b0001000000,
		S_PROBE = 10'b0010000000,
		S_RD    = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [KEY_W-1:0] key_q;
	logic [63:0]      x_q;
	logic [63:0]      pp0_q;
	logic [31:0]      pp1_q, pp2_q;
	logic [HW-1:0]    a_q, s_q;
	logic [AW-1:0]    b_q, rd_q;
	logic [PW-1:0]    p_q;
	row_t             arow_q;
	res_t             res_q, res_d;
	logic [UNQ_W-1:0] uniq_q;
	logic             out_v_q;
	res_t             out_q;
	logic [UNQ_W-1:0] out_uniq_q;

	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	row_t             ram_wdata, rrow;
	logic [$bits(row_t)-1:0] ram_rdata;

	logic [63:0] mul_c, pp0_d, prod, mixed, x0;
	logic [31:0] pp1_d, pp2_d;
	logic        a_hit, b_hit, s_hit, load_out, take, inc_uniq;

	tchc_ram #(.W($bits(row_t)), .D(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rrow = row_t'(ram_rdata);

	// 64-bit mix multiply split into three 32x32 products
	assign x0    = {2'b0, req.key_in} ^ ({2'b0, req.key_in} >> MIX_SH);
	assign mul_c = (state_q == S_M1) ? MIX_C1 : MIX_C2;
	assign pp0_d = 64'(x_q[31:0]) * 64'(mul_c[31:0]);
	assign pp1_d = x_q[31:0] * mul_c[63:32];
	assign pp2_d = x_q[63:32] * mul_c[31:0];
	assign prod  = pp0_q + {pp1_q + pp2_q, 32'b0};
	assign mixed = prod ^ (prod >> MIX_SH);

	assign a_hit = arow_q.valid && (arow_q.key == key_q);
	assign b_hit = rrow.valid && (rrow.key == key_q);
	assign s_hit = b_hit;

	assign take     = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_v_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = clr_q;
		ram_wdata = '0;
		res_d     = res_q;
		inc_uniq  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == AW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.opcode == OP_READ) begin
					ram_addr = AW'(req.slot_index);
				end else begin
					ram_addr = {1'b0, req.key_in[HW-1:0]};
				end
				if (take) begin
					state_d = (req.opcode == OP_READ) ? S_RD : S_M1;
				end
			end
			S_M1: state_d = S_A1;
			S_A1: state_d = S_M2;
			S_M2: state_d = S_A2;
			S_A2: begin
				ram_addr = {1'b1, mixed[HW-1:0]};
				state_d  = S_CHK;
			end
			S_CHK, S_PROBE: begin
				state_d = S_DONE;
				if (state_q == S_CHK && a_hit) begin
					ram_addr = {1'b0, a_q};
					ram_we   = 1'b1;
					ram_wdata = '{1'b1, key_q,
						(&arow_q.cnt) ? arow_q.cnt : arow_q.cnt + 1'b1};
					res_d = '{ST_INC, IDX_W'({1'b0, a_q}), key_q, ram_wdata.cnt, 1'b1};
				end else if (s_hit) begin
					ram_addr = (state_q == S_CHK) ? b_q : {1'b0, s_q};
					ram_we   = 1'b1;
					ram_wdata = '{1'b1, key_q, (&rrow.cnt) ? rrow.cnt : rrow.cnt + 1'b1};
					res_d = '{ST_INC, IDX_W'(ram_addr), key_q, ram_wdata.cnt, 1'b1};
				end else if (state_q == S_CHK && !arow_q.valid) begin
					ram_addr  = {1'b0, a_q};
					ram_we    = 1'b1;
					ram_wdata = '{1'b1, key_q, CNT_W'(1)};
					inc_uniq  = 1'b1;
					res_d = '{ST_INS, IDX_W'(ram_addr), key_q, CNT_W'(1), 1'b1};
				end else if (!rrow.valid) begin
					ram_addr  = (state_q == S_CHK) ? b_q : {1'b0, s_q};
					ram_we    = 1'b1;
					ram_wdata = '{1'b1, key_q, CNT_W'(1)};
					inc_uniq  = 1'b1;
					res_d = '{ST_INS, IDX_W'(ram_addr), key_q, CNT_W'(1), 1'b1};
				end else if (state_q == S_CHK) begin
					ram_addr = {1'b0, a_q + 1'b1};
					state_d  = S_PROBE;
				end else if (p_q == PW'(MAX_PROBES - 1)) begin
					res_d = '{ST_DROP, '0, key_q, '0, 1'b0};
				end else begin
					ram_addr = {1'b0, s_q + 1'b1};
					state_d  = S_PROBE;
				end
			end
			S_RD: begin
				res_d = '{ST_READ, IDX_W'(rd_q), rrow.valid ? rrow.key : '0,
					rrow.valid ? rrow.cnt : '0, rrow.valid};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			uniq_q  <= '0;
			out_v_q <= 1'b0;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (inc_uniq && !(&uniq_q)) begin
				uniq_q <= uniq_q + 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == S_CHK) begin
				p_q <= '0;
			end else if (state_q == S_PROBE) begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= req.key_in;
			x_q   <= x0;
			a_q   <= req.key_in[HW-1:0];
			rd_q  <= AW'(req.slot_index);
		end
		if (state_q == S_M1 || state_q == S_M2) begin
			pp0_q <= pp0_d;
			pp1_q <= pp1_d;
			pp2_q <= pp2_d;
		end
		if (state_q == S_M1) begin
			arow_q <= rrow;
		end
		if (state_q == S_A1) begin
			x_q <= mixed;
		end
		if (state_q == S_A2) begin
			b_q <= {1'b1, mixed[HW-1:0]};
		end
		if (state_q == S_CHK) begin
			s_q <= a_q + 1'b1;
		end else if (state_q == S_PROBE) begin
			s_q <= s_q + 1'b1;
		end
		res_q <= res_d;
		if (load_out) begin
			out_q      <= res_q;
			out_uniq_q <= uniq_q;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_q.status;
	assign rsp.slot_out     = out_q.slot;
	assign rsp.key_out      = out_q.key;
	assign rsp.count_out    = out_q.cnt;
	assign rsp.occupied     = out_q.occ;
	assign rsp.unique_total = out_uniq_q;
endmodule

>>> src/tchc_checker.sv
// port checker for the two-choice hash counter and its bind
module tchc_checker import tchc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       status,
	input logic [IDX_W-1:0] slot_out,
	input logic [CNT_W-1:0] count_out,
	input logic [KEY_W-1:0] key_out,
	input logic             occupied,
	input logic [UNQ_W-1:0] unique_total
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(count_out))
		else $error("stalled word changed");

	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_INS |-> occupied && count_out == 1 && unique_total != 0)
		else $error("insert word malformed");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_DROP |-> !occupied && count_out == 0 && slot_out == 0)
		else $error("drop word malformed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_READ && !occupied |-> count_out == 0 && key_out == 0)
		else $error("empty slot read not zero");
endmodule

bind two_choice_hash_counter tchc_checker u_tchc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.slot_out     (rsp.slot_out),
	.count_out    (rsp.count_out),
	.key_out      (rsp.key_out),
	.occupied     (rsp.occupied),
	.unique_total (rsp.unique_total)
);
